// ----- rtl/core/amb_pkg.sv -----
// Package for the accelerometer magnitude band-pass block.
// Holds section counts, store geometry, fixed Q3.28 biquad coefficients and rounding.
// No dependencies.
package amb_pkg;

    localparam int HP_SECTIONS    = 3;
    localparam int LP_SECTIONS    = 3;
    localparam int SECTIONS       = HP_SECTIONS + LP_SECTIONS;
    localparam int TABLE_SECTIONS = 3;
    localparam int STORE_DEPTH    = 4 * SECTIONS;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int SEC_W          = $clog2(SECTIONS);

    localparam logic signed [31:0] Q28_ONE = 32'sd268435456;

    localparam logic signed [31:0] HP_COEF [TABLE_SECTIONS][5] = '{
        '{ 32'sd255130678, -32'sd255130678, 32'sd0, 32'sd260132055, 32'sd0 },
        '{ 32'sd268435456, -32'sd536870912, 32'sd268435456, 32'sd523307786,
           -32'sd255130678 },
        '{ 32'sd268435456, -32'sd536870912, 32'sd268435456, 32'sd531447524,
           -32'sd263274435 }
    };

    localparam logic signed [31:0] LP_COEF [TABLE_SECTIONS][5] = '{
        '{ 32'sd1861117, 32'sd3722231, 32'sd1861117, 32'sd87219968, 32'sd0 },
        '{ 32'sd268435456, 32'sd536870912, 32'sd268435456, 32'sd190730242,
           -32'sd56054211 },
        '{ 32'sd268435456, 32'sd268435456, 32'sd0, 32'sd252451843, -32'sd161061274 }
    };

    // Coefficient k (b0, b1, b2, a1, a2) of a section; sections past the table pass through.
    function automatic logic signed [31:0] coef(input logic [SEC_W-1:0] sec,
                                                input logic [2:0] k);
        logic        is_hp;
        int unsigned idx;
        logic signed [31:0] c;
        is_hp = (int'(sec) < HP_SECTIONS);
        idx   = is_hp ? int'(sec) : int'(sec) - HP_SECTIONS;
        c     = '0;
        if (k <= 3'd4) begin
            if (idx < TABLE_SECTIONS) begin
                c = is_hp ? HP_COEF[idx[1:0]][k] : LP_COEF[idx[1:0]][k];
            end else begin
                c = (k == 3'd0) ? Q28_ONE : 32'sd0;
            end
        end
        return c;
    endfunction

    // Add half, shift right by 28, saturate to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc);
        logic signed [63:0] v;
        logic signed [35:0] q;
        logic signed [31:0] r;
        v = acc + 64'sd134217728;
        q = v[63:28];
        if (q > 36'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (q < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/accel_magnitude_bandpass.sv -----
// Top level of the accelerometer magnitude band-pass block.
// Depends on amb_pkg.
//
// Each request passes through squaring of the three axes, a bit-by-bit
// square root and the six biquad sections in turn on one shared 32x32
// multiply-accumulate unit, between an entry state and an output state
// that hands over the result. The filter delay words live in
// a 24-word synchronous memory with one read and one write port; per-word
// valid flags make it read as zero after reset without a clearing pass. One
// request is worked at a time; a finished result waits in the output register
// while the next request is taken.
module accel_magnitude_bandpass
    import amb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_highpass_value,
    output logic signed [31:0] m_bandpass_value
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQ   = 5'b00010,
        ST_ROOT = 5'b00100,
        ST_BIQ  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [1:0]         sq_cnt_reg;
    logic [31:0]        sum_reg;
    logic [39:0]        rem_reg, res_reg, bit_reg;
    logic [4:0]         root_cnt_reg;

    logic [SEC_W-1:0]   sec_reg;
    logic [2:0]         ph_reg;
    logic signed [31:0] xcur_reg, x1_reg, y1_reg, hp_reg;
    logic signed [63:0] prod_reg, acc_reg;

    logic [31:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]  wvalid_reg;
    logic [31:0]             rd_raw_reg;
    logic                    rvalid_reg;
    logic [ADDR_W-1:0]       raddr;
    logic [ADDR_W-1:0]       waddr;
    logic [31:0]             wdata;
    logic                    we;
    logic signed [31:0]      rd;
    logic signed [31:0]      mul_b;
    logic signed [31:0]      y_next;
    logic signed [15:0]      sq_sel;
    logic signed [31:0]      sq_val;
    logic [39:0]             root_try;
    logic                    m_valid_reg;
    logic signed [31:0]      m_hp_reg, m_bp_reg;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_highpass_value = m_hp_reg;
    assign m_bandpass_value = m_bp_reg;

    assign rd     = rvalid_reg ? $signed(rd_raw_reg) : 32'sd0;
    assign raddr  = ADDR_W'({sec_reg, ph_reg[1:0]});
    assign mul_b  = (ph_reg != 3'd0) ? rd :
                    (sec_reg == '0) ? $signed({12'd0, res_reg[19:0]}) : xcur_reg;
    assign y_next = round_sat(acc_reg);

    assign sq_sel   = (sq_cnt_reg == 2'd0) ? ax_reg : (sq_cnt_reg == 2'd1) ? ay_reg : az_reg;
    assign sq_val   = sq_sel * sq_sel;
    assign root_try = res_reg + bit_reg;

    always_comb begin
        we    = 1'b0;
        waddr = ADDR_W'({sec_reg, 2'd0});
        wdata = xcur_reg;
        if (state_reg == ST_BIQ) begin
            case (ph_reg)
                3'd1: begin
                    we    = 1'b1;
                    waddr = ADDR_W'({sec_reg, 2'd0});
                    wdata = xcur_reg;
                end
                3'd2: begin
                    we    = 1'b1;
                    waddr = ADDR_W'({sec_reg, 2'd1});
                    wdata = x1_reg;
                end
                3'd4: begin
                    we    = 1'b1;
                    waddr = ADDR_W'({sec_reg, 2'd3});
                    wdata = y1_reg;
                end
                3'd6: begin
                    we    = 1'b1;
                    waddr = ADDR_W'({sec_reg, 2'd2});
                    wdata = y_next;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_raw_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                wvalid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= wvalid_reg[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            sq_cnt_reg  <= '0;
            root_cnt_reg <= '0;
            sec_reg     <= '0;
            ph_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ax_reg     <= s_accel_x;
                        ay_reg     <= s_accel_y;
                        az_reg     <= s_accel_z;
                        sum_reg    <= '0;
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    sum_reg    <= sum_reg + $unsigned(sq_val);
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd2) begin
                        rem_reg      <= {sum_reg + $unsigned(sq_val), 8'd0};
                        res_reg      <= '0;
                        bit_reg      <= 40'h1 << 38;
                        root_cnt_reg <= '0;
                        state_reg    <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (rem_reg >= root_try) begin
                        rem_reg <= rem_reg - root_try;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg      <= bit_reg >> 2;
                    root_cnt_reg <= root_cnt_reg + 5'd1;
                    if (root_cnt_reg == 5'd19) begin
                        state_reg <= ST_BIQ;
                        sec_reg   <= '0;
                        ph_reg    <= '0;
                    end
                end
                ST_BIQ: begin
                    if (ph_reg == 3'd0 && sec_reg == '0) begin
                        xcur_reg <= $signed({12'd0, res_reg[19:0]});
                    end
                    prod_reg <= coef(sec_reg, ph_reg) * mul_b;
                    acc_reg  <= (ph_reg == 3'd0) ? 64'sd0 : acc_reg + prod_reg;
                    if (ph_reg == 3'd1) begin
                        x1_reg <= rd;
                    end
                    if (ph_reg == 3'd3) begin
                        y1_reg <= rd;
                    end
                    if (ph_reg == 3'd6) begin
                        xcur_reg <= y_next;
                        ph_reg   <= '0;
                        if (int'(sec_reg) == HP_SECTIONS - 1) begin
                            hp_reg <= y_next;
                        end
                        if (int'(sec_reg) == SECTIONS - 1) begin
                            state_reg <= ST_OUT;
                        end else begin
                            sec_reg <= sec_reg + SEC_W'(1);
                        end
                    end else begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_hp_reg    <= hp_reg;
                        m_bp_reg    <= xcur_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (int'(waddr) < STORE_DEPTH))
        else $error("delay store write out of range");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BIQ) |-> (ph_reg <= 3'd6 && int'(sec_reg) < SECTIONS))
        else $error("section sequencer out of range");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SQ))
        else $error("accepted request did not start");

endmodule
